[hdl/iafpu_pkg.sv]
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Shared constants for the angle frame parser with yaw unwrap.
// ----------------------------------------------------------------------------
package iafpu_pkg;

	// Default geometry of a burst and turn counter width.
	localparam int FRAME_BYTES_DEF      = 11;
	localparam int FRAMES_PER_BURST_DEF = 3;
	localparam int TURN_BITS_DEF        = 16;

	// Frame codes.
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] ANGLE_KIND  = 8'h53;

	// Register file.
	localparam int          PADDR_W             = 3;
	localparam int          PDATA_W             = 32;
	localparam logic        REG_IDX_THRESHOLD   = 1'b0;
	localparam logic [15:0] UNWRAP_THRESH_RESET = 16'd54613;

	// Stream widths.
	localparam int IN_TDATA_W  = 8;
	localparam int ANGLE_W     = 16;
	localparam int CONT_OUT_W  = 33;
	localparam int OUT_FIELD_W = 3 * ANGLE_W + CONT_OUT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

[hdl/imu_angle_frame_parser_unwrap.sv]
// ----------------------------------------------------------------------------
// IMU angle frame parser with yaw unwrap
// Parses serial bytes into angle frames and extends yaw with a turn counter.
// ----------------------------------------------------------------------------
// Result path: a yaw high byte that is accepted puts its result word into the
// output register, or into the skid stage while the output is stalled.
// Throughput: one byte per cycle while the skid stage is empty; the parser and
// unwrap logic sit between the byte handshake and the output register, and a skid
// stage keeps input open while one result waits. Reset clears the position, abort
// flag, frame type, previous yaw, turn count and sets the threshold to its default.
module imu_angle_frame_parser_unwrap #(
	parameter int FRAME_BYTES      = iafpu_pkg::FRAME_BYTES_DEF,
	parameter int FRAMES_PER_BURST = iafpu_pkg::FRAMES_PER_BURST_DEF,
	parameter int TURN_BITS        = iafpu_pkg::TURN_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input byte stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [iafpu_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] rx_byte
	input  logic [0:0]                          s_tuser,  // [0] burst_start
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] pitch_raw, [31:16] roll_raw, [47:32] yaw_raw,
	// [80:48] yaw_continuous, [87:81] zero
	output logic [iafpu_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [iafpu_pkg::PADDR_W-1:0]       paddr,
	input  logic [iafpu_pkg::PDATA_W-1:0]       pwdata,
	output logic [iafpu_pkg::PDATA_W-1:0]       prdata,
	output logic                                pready
);

	localparam int OFF_W  = $clog2(FRAME_BYTES);
	localparam int FRM_W  = $clog2(FRAMES_PER_BURST + 1);
	localparam int CONT_W = (TURN_BITS + 17 > iafpu_pkg::CONT_OUT_W) ?
		TURN_BITS + 17 : iafpu_pkg::CONT_OUT_W;
	localparam logic [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

	// Control state.
	logic [OFF_W-1:0]     off_q;
	logic [FRM_W-1:0]     frm_q;
	logic                 abort_q;
	logic [7:0]           kind_q;
	logic [15:0]          prev_yaw_q;
	logic [TURN_BITS-1:0] turn_q;
	logic [15:0]          thresh_q;
	logic [15:0]          gather_q [3];

	// Output register and skid stage.
	logic                             m_valid_q;
	logic [iafpu_pkg::OUT_TDATA_W-1:0] m_data_q;
	logic                             skid_valid_q;
	logic [iafpu_pkg::OUT_TDATA_W-1:0] skid_data_q;

	logic                 acc;
	logic [7:0]           rx;
	logic [OFF_W-1:0]     off_cur, off_nxt, off_rel;
	logic [FRM_W-1:0]     frm_cur, frm_nxt;
	logic                 abort_cur, abort_nxt;
	logic [7:0]           kind_nxt;
	logic                 full;
	logic                 byte_en;
	logic                 emit;
	logic [1:0]           gidx;
	logic [15:0]          yaw_new;
	logic signed [16:0]   diff;
	logic signed [16:0]   thr_pos, thr_neg;
	logic                 turn_inc, turn_dec;
	logic [TURN_BITS-1:0] turn_nxt;
	logic [CONT_W-1:0]    cont_full;
	logic [iafpu_pkg::OUT_TDATA_W-1:0] res_data;
	logic                 res;
	logic                 out_free;
	logic                 cfg_wr;

	assign acc      = s_tvalid & s_tready;
	assign rx       = s_tdata;
	assign s_tready = ~skid_valid_q;

	// Byte position, abort and frame type handling.
	always_comb begin
		off_cur   = s_tuser[0] ? '0 : off_q;
		frm_cur   = s_tuser[0] ? '0 : frm_q;
		abort_cur = s_tuser[0] ? 1'b0 : abort_q;
		full      = (frm_cur == FRM_W'(FRAMES_PER_BURST));
		off_nxt   = off_cur;
		frm_nxt   = frm_cur;
		abort_nxt = abort_cur;
		kind_nxt  = kind_q;
		byte_en   = 1'b0;
		emit      = 1'b0;
		if (!full) begin
			if (off_cur == OFF_W'(FRAME_BYTES - 1)) begin
				off_nxt = '0;
				frm_nxt = frm_cur + 1'b1;
			end else begin
				off_nxt = off_cur + 1'b1;
			end
			if (!abort_cur) begin
				if (off_cur == '0) begin
					if (rx != iafpu_pkg::HEADER_BYTE) begin
						abort_nxt = 1'b1;
					end
				end else if (off_cur == OFF_W'(1)) begin
					kind_nxt = rx;
				end else if (kind_q == iafpu_pkg::ANGLE_KIND && off_cur <= OFF_W'(7)) begin
					byte_en = 1'b1;
					emit    = (off_cur == OFF_W'(7));
				end
			end
		end
	end

	// Angle bytes 2..7 map to pitch, roll, yaw; odd offsets are high bytes.
	assign off_rel = off_cur - OFF_W'(2);
	assign gidx    = off_rel[2:1];

	// Yaw unwrap: the jump is compared at 17 bits so it never wraps.
	always_comb begin
		yaw_new  = {rx, gather_q[2][7:0]};
		diff     = $signed({yaw_new[15], yaw_new}) - $signed({prev_yaw_q[15], prev_yaw_q});
		thr_pos  = $signed({1'b0, thresh_q});
		thr_neg  = -thr_pos;
		turn_dec = (diff > thr_pos) && (turn_q != TURN_MIN);
		turn_inc = (diff < thr_neg) && (turn_q != TURN_MAX);
		if (turn_inc) begin
			turn_nxt = turn_q + 1'b1;
		end else if (turn_dec) begin
			turn_nxt = turn_q - 1'b1;
		end else begin
			turn_nxt = turn_q;
		end
		cont_full = {{(CONT_W-TURN_BITS-16){turn_nxt[TURN_BITS-1]}}, turn_nxt, 16'h0000}
			+ {{(CONT_W-16){yaw_new[15]}}, yaw_new};
		res_data  = {{(iafpu_pkg::OUT_TDATA_W-iafpu_pkg::OUT_FIELD_W){1'b0}},
			cont_full[iafpu_pkg::CONT_OUT_W-1:0], yaw_new, gather_q[1], gather_q[0]};
	end

	assign res = acc & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q      <= '0;
			frm_q      <= '0;
			abort_q    <= 1'b0;
			kind_q     <= '0;
			prev_yaw_q <= '0;
			turn_q     <= '0;
		end else if (acc) begin
			off_q   <= off_nxt;
			frm_q   <= frm_nxt;
			abort_q <= abort_nxt;
			kind_q  <= kind_nxt;
			if (emit) begin
				prev_yaw_q <= yaw_new;
				turn_q     <= turn_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && byte_en) begin
			if (off_cur[0]) begin
				gather_q[gidx][15:8] <= rx;
			end else begin
				gather_q[gidx][7:0] <= rx;
			end
		end
	end

	// Output register with one skid entry.
	assign out_free = ~m_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q    <= skid_valid_q | res;
			skid_valid_q <= 1'b0;
		end else if (res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			m_data_q <= skid_valid_q ? skid_data_q : res_data;
		end else if (res) begin
			skid_data_q <= res_data;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready &
		(paddr[2] == iafpu_pkg::REG_IDX_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= iafpu_pkg::UNWRAP_THRESH_RESET;
		end else if (cfg_wr) begin
			thresh_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == iafpu_pkg::REG_IDX_THRESHOLD) ?
		{16'h0000, thresh_q} : '0;

endmodule

[hdl/iafpu_checker.sv]
// ----------------------------------------------------------------------------
// IMU angle frame parser checker
// Port-level checks on the parser's streams.
// ----------------------------------------------------------------------------
module iafpu_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [iafpu_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The low half of the continuous yaw is always the wrapped yaw.
	a_cont_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:48] == m_tdata[47:32])
		else $error("continuous yaw disagrees with wrapped yaw");

	// A fresh result needs an input byte accepted in the previous cycle.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result appeared without an input word");

	// The padding bits above the continuous yaw stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[iafpu_pkg::OUT_TDATA_W-1:iafpu_pkg::OUT_FIELD_W] == '0)
		else $error("padding bits set in result word");

endmodule

bind imu_angle_frame_parser_unwrap iafpu_checker u_iafpu_checker (.*);
